// File: hw/rtl/sliding_second_derivative_heat_capacity_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the heat capacity core
// Concurrent assertion shorthands, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SLIDING_SECOND_DERIVATIVE_HEAT_CAPACITY_CORE_DEFINES_SVH
`define SLIDING_SECOND_DERIVATIVE_HEAT_CAPACITY_CORE_DEFINES_SVH

// Same-cycle implication.
`define SSDHC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SSDHC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/ssdhc_pkg.sv
// ----------------------------------------------------------------------------
// Heat capacity core package
// Field widths, fixed constants and register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ssdhc_pkg;

  localparam int DEF_MAX_HALF_WIDTH = 100;

  localparam int HW_W    = 7;
  localparam int STEP_W  = 23;
  localparam int TEMP_W  = 26;
  localparam int CEN_W   = 27;
  localparam int FE_W    = 32;
  localparam int HC_W    = 32;
  localparam int COEF_W  = 22;
  localparam int WGT_W   = 24;
  localparam int DLT_W   = 18;
  localparam int ABSD_W  = 42;
  localparam int MUL_W   = 33;
  localparam int PROD_W  = 66;
  localparam int ACC_W   = 64;
  localparam int WIDE_W  = 128;

  localparam int KELVIN_OFFSET = 17901158;

  localparam logic [HW_W-1:0]   RST_HALF_WIDTH = 7'd2;
  localparam logic [STEP_W-1:0] RST_STEP       = 23'd65536;
  localparam logic [TEMP_W-1:0] RST_START      = 26'd0;
  localparam logic [TEMP_W-1:0] RST_END        = 26'd6553600;

  typedef enum logic [1:0] {
    CFG_HALF_WIDTH = 2'd0,
    CFG_TEMP_STEP  = 2'd1,
    CFG_START_TEMP = 2'd2,
    CFG_END_TEMP   = 2'd3
  } cfg_index_t;

endpackage

// File: hw/rtl/sliding_second_derivative_heat_capacity_core.sv
// ----------------------------------------------------------------------------
// Sliding second derivative heat capacity core
// Savitzky-Golay quadratic second derivative over free-energy samples.
// ----------------------------------------------------------------------------
// Usage: free-energy samples enter on the in_ channel (tdata = sample, tuser =
// restart), one transaction per temperature step. Once 2m+1 samples are held,
// each sample of the sweep produces one out_ transaction with the centre temperature
// and heat capacity (tdata), the flag (tuser) and the end-of-sweep marker (tlast).
// The user writes registers through cfg_ only while the block is idle; the block
// does not enforce it. Every write empties the window and restarts the sweep.
// Flow: in_tready is high only while the sequencer is idle. A sample that
// yields no result leaves the sequencer idle. A sample that yields a result
// runs a multiply-accumulate over the n = 2m+1 window taps through the shared
// 33 x 33 multiplier reading the window memory, then set-up steps, the two
// 64 x 64 products built from 32-bit partial products, and the 128-bit
// restoring divider, one quotient bit per cycle.
// Stall: the result sits in an output register; a new sample may be taken
// while it waits, and the next result waits for that register to empty.
// Reset: registers return to their defaults, the window is empty, the sweep
// begins at the effective start temperature. No clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sliding_second_derivative_heat_capacity_core_defines.svh"

module sliding_second_derivative_heat_capacity_core
  import ssdhc_pkg::*;
#(
  parameter int MAX_HALF_WIDTH = DEF_MAX_HALF_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // Sample stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] free_energy
  input  logic        in_tuser,   // [0] restart
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [25:0] center_temperature, [57:26] heat capacity
  output logic        out_tuser,  // [0] flagged
  output logic        out_tlast,  // sweep_last
  // Configuration writes
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [25:0] cfg_data
);

  localparam int DEPTH  = 2 * MAX_HALF_WIDTH + 1;
  localparam int AW     = $clog2(DEPTH);
  localparam int HELD_W = $clog2(DEPTH + 1);
  localparam int NTAB   = 2 ** HW_W;
  localparam logic signed [CEN_W-1:0] T_ABS_ZERO = CEN_W'(-KELVIN_OFFSET);

  typedef enum logic [3:0] {
    S_IDLE, S_MAC, S_DRAIN, S_PREP, S_LDDEN, S_LM, S_DIV, S_SAT, S_OUT
  } state_t;

  // Configuration registers.
  logic [HW_W-1:0]   half_width_r;
  logic [STEP_W-1:0] step_r;
  logic [TEMP_W-1:0] start_r;
  logic [TEMP_W-1:0] end_r;

  // Coefficient tables, indexed by half width, worked out at elaboration.
  logic [COEF_W-1:0]       a_tab   [NTAB];
  logic [COEF_W-1:0]       nm2_tab [NTAB];
  logic signed [DLT_W-1:0] dlt_tab [NTAB];
  logic [ABSD_W-1:0]       absd_tab[NTAB];

  for (genvar g = 0; g < NTAB; g++) begin : g_tab
    localparam longint M = longint'(g);
    localparam longint N = 2 * M + 1;
    assign a_tab[g]    = COEF_W'(M * (M + 1) * N / 3);
    assign nm2_tab[g]  = COEF_W'(N * M * M);
    assign dlt_tab[g]  = DLT_W'(N * (1 - 2 * M));
    assign absd_tab[g] = ABSD_W'(N * N * (N * N - 1) * (N * N - 4) / 180);
  end

  // Effective sweep set-up.
  logic signed [CEN_W-1:0] st_s, en_s, lo_raw, lo_eff, hi_eff, span;
  logic [STEP_W-1:0]       h_eff;
  logic [7:0]              n_w;

  always_comb begin
    st_s   = CEN_W'($signed(start_r));
    en_s   = CEN_W'($signed(end_r));
    lo_raw = (st_s > en_s) ? en_s : st_s;
    hi_eff = (st_s > en_s) ? st_s : en_s;
    lo_eff = (lo_raw < T_ABS_ZERO) ? T_ABS_ZERO : lo_raw;
    span   = hi_eff - lo_eff;
    if (span < 0) begin
      h_eff = '0;
    end else if ($signed({4'b0, step_r}) > span) begin
      h_eff = span[STEP_W-1:0];
    end else begin
      h_eff = step_r;
    end
    n_w = {half_width_r, 1'b1};
  end

  // Sequencer registers.
  state_t                  state_r;
  logic [AW-1:0]           wp_r, addr_r;
  logic [HELD_W-1:0]       held_r;
  logic signed [CEN_W-1:0] center_r;
  logic                    cen_ok_r, done_r;
  logic [7:0]              tap_r;
  logic signed [WGT_W-1:0] nx2_r, w_d_r;
  logic signed [DLT_W-1:0] dlt_r;
  logic [FE_W-1:0]         rdata_r;
  logic                    v1_r, v2_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                    neg_r, job_r, flag_r;
  logic [63:0]             mag_r, opa_r, opb_r;
  logic [TEMP_W-1:0]       tk_r;
  logic [2:0]              lm_cnt_r;
  logic [WIDE_W-1:0]       lm_acc_r, den_r, dvd_r, dvs_r, rem_r, quo_r;
  logic [6:0]              bit_r;
  logic [HC_W-1:0]         hq_r;
  logic                    out_valid_r, out_flag_r, out_last_r;
  logic [TEMP_W-1:0]       out_center_r;
  logic [HC_W-1:0]         out_heat_r;

  logic [FE_W-1:0] mem [DEPTH];

  // Transaction-time values.
  logic                    in_acc;
  logic [HELD_W-1:0]       held_base, held_new, n_held;
  logic signed [CEN_W-1:0] center_v, center_next;
  logic                    done_v, last_v;
  logic [AW-1:0]           wp_new, base;
  logic [AW:0]             base_raw;
  logic signed [WGT_W-1:0] w_cur;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign n_held    = HELD_W'(n_w);

  always_comb begin
    held_base   = in_tuser ? '0 : held_r;
    held_new    = (held_base >= n_held) ? n_held : held_base + 1'b1;
    center_v    = (in_tuser || !cen_ok_r) ? lo_eff : center_r;
    done_v      = in_tuser ? 1'b0 : done_r;
    wp_new      = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    base_raw    = {1'b0, wp_new} + (AW + 1)'(DEPTH) - (AW + 1)'(n_w);
    base        = (base_raw >= (AW + 1)'(DEPTH)) ? AW'(base_raw - (AW + 1)'(DEPTH))
                                                 : base_raw[AW-1:0];
    w_cur       = $signed({2'b0, a_tab[half_width_r]}) - nx2_r;
    center_next = center_r + $signed({4'b0, h_eff});
    last_v      = (h_eff == '0) || (center_next > hi_eff);
  end

  // Shared multiplier.
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;

  always_comb begin
    unique case (state_r)
      S_PREP: begin
        mul_a = $signed({10'b0, h_eff});
        mul_b = $signed({10'b0, h_eff});
      end
      S_LM: begin
        mul_a = $signed({1'b0, lm_cnt_r[2] ? opa_r[63:32] : opa_r[31:0]});
        mul_b = $signed({1'b0, lm_cnt_r[1] ? opb_r[63:32] : opb_r[31:0]});
      end
      default: begin
        mul_a = $signed({rdata_r[FE_W-1], rdata_r});
        mul_b = $signed({{(MUL_W - WGT_W){w_d_r[WGT_W-1]}}, w_d_r});
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Partial product accumulation for the long multiplies.
  logic [WIDE_W-1:0] lm_term, lm_sum;

  always_comb begin
    unique case (lm_cnt_r[2:1])
      2'b00:   lm_term = {64'b0, prod_r[63:0]};
      2'b11:   lm_term = {prod_r[63:0], 64'b0};
      default: lm_term = {32'b0, prod_r[63:0], 32'b0};
    endcase
    lm_sum = lm_acc_r + lm_term;
  end

  // Divider step.
  logic [WIDE_W-1:0] rem_sh;
  logic              div_ge;
  logic [HC_W-1:0]   limit;

  always_comb begin
    rem_sh = {rem_r[WIDE_W-2:0], dvd_r[WIDE_W-1]};
    div_ge = (rem_sh >= dvs_r);
    limit  = neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
  end

  // Window memory: one write per accepted sample, one registered read.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem[wp_r] <= in_tdata;
    end
    rdata_r <= mem[addr_r];
  end

  // Sequencer, datapath and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      half_width_r <= RST_HALF_WIDTH;
      step_r       <= RST_STEP;
      start_r      <= RST_START;
      end_r        <= RST_END;
      wp_r         <= '0;
      addr_r       <= '0;
      held_r       <= '0;
      cen_ok_r     <= 1'b0;
      done_r       <= 1'b0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      prod_r <= mul_p;
      v1_r   <= (state_r == S_MAC);
      v2_r   <= v1_r;
      if (v2_r) begin
        acc_r <= acc_r + prod_r[ACC_W-1:0];
      end
      // The output step refills the register itself when it frees up.
      if (out_valid_r && out_tready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            center_r <= center_v;
            cen_ok_r <= 1'b1;
            held_r   <= held_new;
            wp_r     <= wp_new;
            if (held_new == n_held && !done_v && center_v > hi_eff) begin
              done_r <= 1'b1;
            end else begin
              done_r <= done_v;
            end
            if (held_new == n_held && !done_v && center_v <= hi_eff) begin
              addr_r  <= base;
              tap_r   <= '0;
              nx2_r   <= $signed({2'b0, nm2_tab[half_width_r]});
              dlt_r   <= dlt_tab[half_width_r];
              acc_r   <= '0;
              state_r <= S_MAC;
            end
          end
        end
        S_MAC: begin
          w_d_r  <= w_cur;
          addr_r <= (addr_r == AW'(DEPTH - 1)) ? '0 : addr_r + 1'b1;
          nx2_r  <= nx2_r + WGT_W'(dlt_r);
          dlt_r  <= dlt_r + $signed({9'b0, n_w, 1'b0});
          tap_r  <= tap_r + 1'b1;
          if (tap_r == n_w - 1'b1) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!v1_r && !v2_r) begin
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          neg_r <= acc_r[ACC_W-1];
          mag_r <= acc_r[ACC_W-1] ? 64'(-acc_r) : 64'(acc_r);
          tk_r  <= TEMP_W'(center_r + CEN_W'(KELVIN_OFFSET));
          if (h_eff == '0) begin
            hq_r    <= '0;
            flag_r  <= 1'b1;
            state_r <= S_OUT;
          end else begin
            state_r <= S_LDDEN;
          end
        end
        S_LDDEN: begin
          opa_r    <= {{(64 - ABSD_W){1'b0}}, absd_tab[half_width_r]};
          opb_r    <= prod_r[63:0];
          lm_acc_r <= '0;
          lm_cnt_r <= '0;
          job_r    <= 1'b0;
          state_r  <= S_LM;
        end
        S_LM: begin
          lm_cnt_r <= lm_cnt_r + 1'b1;
          if (lm_cnt_r[0] && lm_cnt_r != 3'd7) begin
            lm_acc_r <= lm_sum;
          end
          if (lm_cnt_r == 3'd7) begin
            if (!job_r) begin
              den_r    <= lm_sum;
              opa_r    <= mag_r;
              opb_r    <= {{(64 - TEMP_W){1'b0}}, tk_r};
              lm_acc_r <= '0;
              job_r    <= 1'b1;
            end else begin
              // Dividend 2N + Dd and divisor 2Dd give rounding half away from zero.
              dvd_r   <= (lm_sum << 18) + den_r;
              dvs_r   <= den_r << 1;
              rem_r   <= '0;
              quo_r   <= '0;
              bit_r   <= '0;
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          rem_r <= div_ge ? rem_sh - dvs_r : rem_sh;
          quo_r <= {quo_r[WIDE_W-2:0], div_ge};
          dvd_r <= dvd_r << 1;
          bit_r <= bit_r + 1'b1;
          if (bit_r == 7'd127) begin
            state_r <= S_SAT;
          end
        end
        S_SAT: begin
          if ((|quo_r[WIDE_W-1:32]) || (quo_r[31:0] > limit)) begin
            hq_r   <= limit;
            flag_r <= 1'b1;
          end else begin
            hq_r   <= quo_r[31:0];
            flag_r <= 1'b0;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r  <= 1'b1;
            out_center_r <= center_r[TEMP_W-1:0];
            out_heat_r   <= neg_r ? HC_W'(-hq_r) : hq_r;
            out_flag_r   <= flag_r;
            out_last_r   <= last_v;
            center_r     <= center_next;
            if (last_v) begin
              done_r <= 1'b1;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      // A register write restarts the sweep from the new effective start.
      if (cfg_wr_en) begin
        held_r   <= '0;
        cen_ok_r <= 1'b0;
        done_r   <= 1'b0;
        unique case (cfg_index_t'(cfg_index))
          CFG_HALF_WIDTH: begin
            if (cfg_data[HW_W-1:0] == '0) begin
              half_width_r <= HW_W'(1);
            end else if (cfg_data[HW_W-1:0] > HW_W'(MAX_HALF_WIDTH)) begin
              half_width_r <= HW_W'(MAX_HALF_WIDTH);
            end else begin
              half_width_r <= cfg_data[HW_W-1:0];
            end
          end
          CFG_TEMP_STEP:  step_r  <= cfg_data[STEP_W-1:0];
          CFG_START_TEMP: start_r <= cfg_data;
          CFG_END_TEMP:   end_r   <= cfg_data;
          default:        ;
        endcase
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_heat_r, out_center_r};
  assign out_tuser  = out_flag_r;
  assign out_tlast  = out_last_r;

  // Checks on the sequencer.
  `SSDHC_ASSERT_IMP(a_held_bound, 1'b1, held_r <= n_held, "window fill exceeds window length")
  `SSDHC_ASSERT_IMP(a_out_from_seq, $rose(out_valid_r), $past(state_r == S_OUT),
                    "result appeared outside the output step")
  `SSDHC_ASSERT_NXT(a_div_rem, state_r == S_DIV, rem_r < dvs_r || state_r == S_SAT,
                    "divider remainder not below divisor")

endmodule
